FILE: hw/rtl/mlp_three_layer_inference_defines.svh
// Assertion macros shared by the checker of the three-layer perceptron block.
// Needs no other file; the checker takes it in by include.
`ifndef MLP_THREE_LAYER_INFERENCE_DEFINES_SVH
`define MLP_THREE_LAYER_INFERENCE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define MLP_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mlp_three_layer_inference: implication failed");

// Next-cycle implication, disabled while reset is high.
`define MLP_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mlp_three_layer_inference: next-cycle implication failed");

`endif

FILE: hw/rtl/mlp_pkg.sv
// Shared types, codes and constant functions of the three-layer perceptron block.
// Depends on nothing; every other source file but the assertion header imports it.
`default_nettype none
package mlp_pkg;

   localparam int MAX_INPUTS_DEF  = 1024;
   localparam int MAX_HIDDEN1_DEF = 128;
   localparam int MAX_HIDDEN2_DEF = 64;
   localparam int MAX_OUTPUTS_DEF = 16;
   localparam int SIG_DEPTH_DEF   = 1024;

   localparam logic [1:0] MODE_WEIGHT = 2'd0;
   localparam logic [1:0] MODE_BIAS   = 2'd1;
   localparam logic [1:0] MODE_ACT    = 2'd2;

   localparam logic [1:0] LAYER_H1  = 2'd0;
   localparam logic [1:0] LAYER_H2  = 2'd1;
   localparam logic [1:0] LAYER_OUT = 2'd2;

   localparam logic [1:0] REG_INPUT_COUNT   = 2'd0;
   localparam logic [1:0] REG_HIDDEN1_COUNT = 2'd1;
   localparam logic [1:0] REG_HIDDEN2_COUNT = 2'd2;
   localparam logic [1:0] REG_OUTPUT_COUNT  = 2'd3;

   localparam logic [10:0] INPUT_COUNT_RST   = 11'd784;
   localparam logic [7:0]  HIDDEN1_COUNT_RST = 8'd128;
   localparam logic [6:0]  HIDDEN2_COUNT_RST = 7'd64;
   localparam logic [4:0]  OUTPUT_COUNT_RST  = 5'd10;

   typedef struct packed {
      logic [10:0] input_count;
      logic [7:0]  hidden1_count;
      logic [6:0]  hidden2_count;
      logic [4:0]  output_count;
   } cfg_type;

   typedef struct packed {
      logic       rd;
      logic       first;
      logic       last;
      logic [1:0] layer;
      logic       publish;
   } cmd_type;

   typedef struct packed {
      logic busy;
      logic rsp_busy;
   } status_type;

   function automatic int max2(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

   function automatic int clog2_min1(input int x);
      return (x > 1) ? $clog2(x) : 1;
   endfunction

   function automatic int clamp_count(input int v, input int max_v);
      int r;
      r = v;
      if (v < 1) r = 1;
      else if (v > max_v) r = max_v;
      return r;
   endfunction

   function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
      logic [63:0] q;
      logic [64:0] r;
      q = '0;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[63:0], n[b]};
         if (r >= {1'b0, d}) begin
            r = r - {1'b0, d};
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic logic [63:0] exp_neg_q31(input logic [31:0] a);
      logic [63:0] y, y2, y3, y4, e;
      y  = {32'd0, a} << 11;
      y2 = (y * y) >> 31;
      y3 = (y2 * y) >> 31;
      y4 = (y3 * y) >> 31;
      e  = (64'd1 << 31) + (y2 >> 1) + y4 / 64'd24 - y - y3 / 64'd6;
      for (int n = 0; n < 8; n++) begin
         e = (e * e) >> 31;
      end
      return e;
   endfunction

   function automatic logic [15:0] sigmoid_entry(input int k, input int depth);
      logic [63:0] cq, e, den, s;
      int xq, a;
      cq  = udiv64(64'(2 * k + 1) * 64'd32768, 64'(depth));
      xq  = int'(cq[31:0]) - 32768;
      a   = (xq < 0) ? -xq : xq;
      e   = exp_neg_q31(32'(a));
      den = (64'd1 << 31) + e;
      if (xq >= 0) s = udiv64((64'd1 << 47) + (den >> 1), den);
      else s = udiv64((e << 16) + (den >> 1), den);
      if (s > 64'd65535) s = 64'd65535;
      return s[15:0];
   endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/mlp_sigmoid_rom.sv
// Sigmoid lookup table with a registered read port.
// Entries are built at elaboration by sigmoid_entry from mlp_pkg.
`default_nettype none
module mlp_sigmoid_rom
   import mlp_pkg::*;
#(
   parameter int SIG_DEPTH = SIG_DEPTH_DEF,
   localparam int AW = clog2_min1(SIG_DEPTH)
) (
   input  wire logic          clock,
   input  wire logic [AW-1:0] rd_addr,
   output logic [15:0]        rd_data
);

   logic [15:0] rom [SIG_DEPTH];
   logic [15:0] rd_data_ff;

   for (genvar k = 0; k < SIG_DEPTH; k++) begin : g_entry
      localparam logic [15:0] Value = sigmoid_entry(k, SIG_DEPTH);
      assign rom[k] = Value;
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= rom[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/mlp_datapath.sv
// Datapath: weight, bias and activation memories, the MAC pipeline, saturation,
// sigmoid lookup, argmax and the result register. Uses mlp_pkg and mlp_sigmoid_rom.
`default_nettype none
module mlp_datapath
   import mlp_pkg::*;
#(
   parameter int MAX_INPUTS  = MAX_INPUTS_DEF,
   parameter int MAX_HIDDEN1 = MAX_HIDDEN1_DEF,
   parameter int MAX_HIDDEN2 = MAX_HIDDEN2_DEF,
   parameter int MAX_OUTPUTS = MAX_OUTPUTS_DEF,
   parameter int SIG_DEPTH   = SIG_DEPTH_DEF,
   localparam int W1_DEPTH = MAX_INPUTS * MAX_HIDDEN1,
   localparam int W2_DEPTH = MAX_HIDDEN1 * MAX_HIDDEN2,
   localparam int W3_DEPTH = MAX_HIDDEN2 * MAX_OUTPUTS,
   localparam int FANIN    = max2(max2(MAX_INPUTS, MAX_HIDDEN1), MAX_HIDDEN2),
   localparam int CNT_W    = $clog2(max2(FANIN, MAX_OUTPUTS) + 1),
   localparam int WA_W     = max2(clog2_min1(max2(max2(W1_DEPTH, W2_DEPTH), W3_DEPTH)), CNT_W)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_fire,
   input  wire logic [1:0]        req_mode,
   input  wire logic [1:0]        req_layer,
   input  wire logic [16:0]       req_index,
   input  wire logic signed [15:0] req_coef,
   input  wire logic [15:0]       req_act,
   input  wire cmd_type           cmd,
   input  wire logic [CNT_W-1:0]  cmd_i,
   input  wire logic [CNT_W-1:0]  cmd_j,
   input  wire logic [WA_W-1:0]   cmd_wa,
   output status_type             status,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [3:0]             rsp_class_index,
   output logic [15:0]            rsp_class_score
);

   localparam int W1_AW  = clog2_min1(W1_DEPTH);
   localparam int W2_AW  = clog2_min1(W2_DEPTH);
   localparam int W3_AW  = clog2_min1(W3_DEPTH);
   localparam int IN_AW  = clog2_min1(MAX_INPUTS);
   localparam int H1_AW  = clog2_min1(MAX_HIDDEN1);
   localparam int H2_AW  = clog2_min1(MAX_HIDDEN2);
   localparam int OUT_AW = clog2_min1(MAX_OUTPUTS);
   localparam int ACC_W  = 34 + clog2_min1(FANIN);
   localparam int TAB_AW = clog2_min1(SIG_DEPTH);
   localparam int DEP_W  = $clog2(SIG_DEPTH + 1);

   logic [31:0] idx32, i32, j32, wa32;
   assign idx32 = 32'(req_index);
   assign i32   = 32'(cmd_i);
   assign j32   = 32'(cmd_j);
   assign wa32  = 32'(cmd_wa);

   logic wr_w, wr_b;
   assign wr_w = req_fire && (req_mode == MODE_WEIGHT);
   assign wr_b = req_fire && (req_mode == MODE_BIAS);

   logic signed [15:0] w1_mem [W1_DEPTH];
   logic signed [15:0] w2_mem [W2_DEPTH];
   logic signed [15:0] w3_mem [W3_DEPTH];
   logic signed [15:0] b1_mem [MAX_HIDDEN1];
   logic signed [15:0] b2_mem [MAX_HIDDEN2];
   logic signed [15:0] b3_mem [MAX_OUTPUTS];
   logic [15:0]        in_mem [MAX_INPUTS];
   logic [15:0]        h1_mem [MAX_HIDDEN1];
   logic [15:0]        h2_mem [MAX_HIDDEN2];

   logic signed [15:0] w1_q_ff, w2_q_ff, w3_q_ff, b1_q_ff, b2_q_ff, b3_q_ff;
   logic [15:0]        in_q_ff, h1_q_ff, h2_q_ff;

   // Pipeline control.
   logic               s1_v_ff, s1_first_ff, s1_last_ff;
   logic [1:0]         s1_layer_ff;
   logic [CNT_W-1:0]   s1_j_ff;
   logic               s2_v_ff, s2_first_ff, s2_last_ff;
   logic [1:0]         s2_layer_ff;
   logic [CNT_W-1:0]   s2_j_ff;
   logic               s3_fin_ff;
   logic [1:0]         s3_layer_ff;
   logic [CNT_W-1:0]   s3_j_ff;
   logic               s4_v_ff;
   logic [1:0]         s4_layer_ff;
   logic [CNT_W-1:0]   s4_j_ff;
   logic               s5_v_ff;
   logic [1:0]         s5_layer_ff;
   logic [CNT_W-1:0]   s5_j_ff;
   logic               s6_v_ff;
   logic [1:0]         s6_layer_ff;
   logic [CNT_W-1:0]   s6_j_ff;

   logic signed [32:0]      prod_ff, prod_in;
   logic signed [15:0]      bias_ff;
   logic signed [ACC_W-1:0] acc_ff, acc_in, prod_ext, bias_ext;
   logic [31:0]             sat_ff, sat_in, u_sat;
   logic [TAB_AW-1:0]       tidx_ff;
   logic [32+DEP_W-1:0]     tidx_wide;
   logic [15:0]             rom_q;
   logic [15:0]             act_sel;
   logic signed [15:0]      w_sel, b_sel;
   logic                    fits;

   logic [CNT_W-1:0] best_idx_ff;
   logic [15:0]      best_score_ff;
   logic             rsp_valid_ff;
   logic [3:0]       rsp_idx_ff;
   logic [15:0]      rsp_score_ff;

   // Memory writes from the input channel and of the first hidden layer's activations.
   always_ff @(posedge clock) begin
      if (wr_w && (req_layer == LAYER_H1) && (idx32 < 32'(W1_DEPTH))) begin
         w1_mem[idx32[W1_AW-1:0]] <= req_coef;
      end
   end
   always_ff @(posedge clock) begin
      if (wr_w && (req_layer == LAYER_H2) && (idx32 < 32'(W2_DEPTH))) begin
         w2_mem[idx32[W2_AW-1:0]] <= req_coef;
      end
   end
   always_ff @(posedge clock) begin
      if (wr_w && (req_layer == LAYER_OUT) && (idx32 < 32'(W3_DEPTH))) begin
         w3_mem[idx32[W3_AW-1:0]] <= req_coef;
      end
   end
   always_ff @(posedge clock) begin
      if (wr_b && (req_layer == LAYER_H1) && (idx32 < 32'(MAX_HIDDEN1))) begin
         b1_mem[idx32[H1_AW-1:0]] <= req_coef;
      end
   end
   always_ff @(posedge clock) begin
      if (wr_b && (req_layer == LAYER_H2) && (idx32 < 32'(MAX_HIDDEN2))) begin
         b2_mem[idx32[H2_AW-1:0]] <= req_coef;
      end
   end
   always_ff @(posedge clock) begin
      if (wr_b && (req_layer == LAYER_OUT) && (idx32 < 32'(MAX_OUTPUTS))) begin
         b3_mem[idx32[OUT_AW-1:0]] <= req_coef;
      end
   end
   always_ff @(posedge clock) begin
      if (req_fire && (req_mode == MODE_ACT) && (idx32 < 32'(MAX_INPUTS))) begin
         in_mem[idx32[IN_AW-1:0]] <= req_act;
      end
   end
   always_ff @(posedge clock) begin
      if (s6_v_ff && (s6_layer_ff == LAYER_H1)) begin
         h1_mem[s6_j_ff[H1_AW-1:0]] <= rom_q;
      end
   end

   // Registered reads for the MAC stream.
   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         w1_q_ff <= w1_mem[wa32[W1_AW-1:0]];
         w2_q_ff <= w2_mem[wa32[W2_AW-1:0]];
         w3_q_ff <= w3_mem[wa32[W3_AW-1:0]];
         b1_q_ff <= b1_mem[j32[H1_AW-1:0]];
         b2_q_ff <= b2_mem[j32[H2_AW-1:0]];
         b3_q_ff <= b3_mem[j32[OUT_AW-1:0]];
         in_q_ff <= in_mem[i32[IN_AW-1:0]];
      end
   end
   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         h1_q_ff <= h1_mem[i32[H1_AW-1:0]];
      end
   end
   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         h2_q_ff <= h2_mem[i32[H2_AW-1:0]];
      end
   end

   always_comb begin
      case (s1_layer_ff)
         LAYER_H1: begin
            act_sel = in_q_ff;
            w_sel   = w1_q_ff;
            b_sel   = b1_q_ff;
         end
         LAYER_H2: begin
            act_sel = h1_q_ff;
            w_sel   = w2_q_ff;
            b_sel   = b2_q_ff;
         end
         default: begin
            act_sel = h2_q_ff;
            w_sel   = w3_q_ff;
            b_sel   = b3_q_ff;
         end
      endcase
   end

   assign prod_in  = $signed({1'b0, act_sel}) * w_sel;
   assign prod_ext = {{(ACC_W-33){prod_ff[32]}}, prod_ff};
   assign bias_ext = {{(ACC_W-32){bias_ff[15]}}, bias_ff, 16'd0};
   assign acc_in   = s2_first_ff ? (bias_ext + prod_ext) : (acc_ff + prod_ext);

   assign fits   = (&acc_ff[ACC_W-1:31]) || !(|acc_ff[ACC_W-1:31]);
   assign sat_in = fits ? acc_ff[31:0] :
                   (acc_ff[ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF);
   assign u_sat  = {~sat_ff[31], sat_ff[30:0]};
   assign tidx_wide = (32+DEP_W)'(u_sat) * (32+DEP_W)'(SIG_DEPTH);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      bias_ff <= b_sel;
      if (s2_v_ff) acc_ff <= acc_in;
      if (s3_fin_ff) sat_ff <= sat_in;
      if (s4_v_ff) tidx_ff <= tidx_wide[32 +: TAB_AW];
      s1_first_ff <= cmd.first;
      s1_last_ff  <= cmd.last;
      s1_layer_ff <= cmd.layer;
      s1_j_ff     <= cmd_j;
      s2_first_ff <= s1_first_ff;
      s2_last_ff  <= s1_last_ff;
      s2_layer_ff <= s1_layer_ff;
      s2_j_ff     <= s1_j_ff;
      s3_layer_ff <= s2_layer_ff;
      s3_j_ff     <= s2_j_ff;
      s4_layer_ff <= s3_layer_ff;
      s4_j_ff     <= s3_j_ff;
      s5_layer_ff <= s4_layer_ff;
      s5_j_ff     <= s4_j_ff;
      s6_layer_ff <= s5_layer_ff;
      s6_j_ff     <= s5_j_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff   <= 1'b0;
         s2_v_ff   <= 1'b0;
         s3_fin_ff <= 1'b0;
         s4_v_ff   <= 1'b0;
         s5_v_ff   <= 1'b0;
         s6_v_ff   <= 1'b0;
      end else begin
         s1_v_ff   <= cmd.rd;
         s2_v_ff   <= s1_v_ff;
         s3_fin_ff <= s2_v_ff && s2_last_ff;
         s4_v_ff   <= s3_fin_ff;
         s5_v_ff   <= s4_v_ff;
         s6_v_ff   <= s5_v_ff;
      end
   end

   mlp_sigmoid_rom #(
      .SIG_DEPTH(SIG_DEPTH)
   ) u_rom (
      .clock  (clock),
      .rd_addr(tidx_ff),
      .rd_data(rom_q)
   );

   // Hidden activations and the running argmax of the output layer.
   always_ff @(posedge clock) begin
      if (s6_v_ff && (s6_layer_ff == LAYER_H2)) begin
         h2_mem[s6_j_ff[H2_AW-1:0]] <= rom_q;
      end
   end

   always_ff @(posedge clock) begin
      if (s6_v_ff && (s6_layer_ff == LAYER_OUT)) begin
         if ((s6_j_ff == '0) || (rom_q > best_score_ff)) begin
            best_idx_ff   <= s6_j_ff;
            best_score_ff <= rom_q;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_idx_ff   <= 4'(32'(best_idx_ff));
         rsp_score_ff <= best_score_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.publish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign status.busy     = s1_v_ff || s2_v_ff || s3_fin_ff || s4_v_ff || s5_v_ff || s6_v_ff;
   assign status.rsp_busy = rsp_valid_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_class_index = rsp_idx_ff;
   assign rsp_class_score = rsp_score_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/mlp_ctrl.sv
// Controller: sequences the three layers neuron by neuron and issues one MAC a cycle.
// Uses mlp_pkg; drives mlp_datapath through cmd_type and reads status_type.
`default_nettype none
module mlp_ctrl
   import mlp_pkg::*;
#(
   parameter int MAX_INPUTS  = MAX_INPUTS_DEF,
   parameter int MAX_HIDDEN1 = MAX_HIDDEN1_DEF,
   parameter int MAX_HIDDEN2 = MAX_HIDDEN2_DEF,
   parameter int MAX_OUTPUTS = MAX_OUTPUTS_DEF,
   localparam int W1_DEPTH = MAX_INPUTS * MAX_HIDDEN1,
   localparam int W2_DEPTH = MAX_HIDDEN1 * MAX_HIDDEN2,
   localparam int W3_DEPTH = MAX_HIDDEN2 * MAX_OUTPUTS,
   localparam int FANIN    = max2(max2(MAX_INPUTS, MAX_HIDDEN1), MAX_HIDDEN2),
   localparam int CNT_W    = $clog2(max2(FANIN, MAX_OUTPUTS) + 1),
   localparam int WA_W     = max2(clog2_min1(max2(max2(W1_DEPTH, W2_DEPTH), W3_DEPTH)), CNT_W)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cfg_type          cfg,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic [1:0]       req_mode,
   input  wire logic             req_last,
   input  wire status_type       status,
   output cmd_type               cmd,
   output logic [CNT_W-1:0]      cmd_i,
   output logic [CNT_W-1:0]      cmd_j,
   output logic [WA_W-1:0]       cmd_wa
);

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_MAC     = 2'd1;
   localparam logic [1:0] ST_DRAIN   = 2'd2;
   localparam logic [1:0] ST_PUBLISH = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [1:0]       layer_ff, layer_in;
   logic [CNT_W-1:0] i_ff, i_in, j_ff, j_in;
   logic [WA_W-1:0]  wa_ff, wa_in;
   logic [CNT_W-1:0] ni, nh1, nh2, no, n_prev, n_next;
   logic             start, i_last, j_last;

   assign ni  = CNT_W'(clamp_count(int'(cfg.input_count), MAX_INPUTS));
   assign nh1 = CNT_W'(clamp_count(int'(cfg.hidden1_count), MAX_HIDDEN1));
   assign nh2 = CNT_W'(clamp_count(int'(cfg.hidden2_count), MAX_HIDDEN2));
   assign no  = CNT_W'(clamp_count(int'(cfg.output_count), MAX_OUTPUTS));

   always_comb begin
      case (layer_ff)
         LAYER_H1: begin
            n_prev = ni;
            n_next = nh1;
         end
         LAYER_H2: begin
            n_prev = nh1;
            n_next = nh2;
         end
         default: begin
            n_prev = nh2;
            n_next = no;
         end
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign start     = req_valid && req_ready && (req_mode == MODE_ACT) && req_last;
   assign i_last    = (i_ff == n_prev - CNT_W'(1));
   assign j_last    = (j_ff == n_next - CNT_W'(1));

   always_comb begin
      state_in = state_ff;
      layer_in = layer_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      wa_in    = wa_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_MAC;
               layer_in = LAYER_H1;
               i_in     = '0;
               j_in     = '0;
               wa_in    = '0;
            end
         end
         ST_MAC: begin
            if (i_last) begin
               i_in = '0;
               if (j_last) begin
                  state_in = ST_DRAIN;
               end else begin
                  j_in  = j_ff + CNT_W'(1);
                  wa_in = WA_W'(j_ff) + WA_W'(1);
               end
            end else begin
               i_in  = i_ff + CNT_W'(1);
               wa_in = wa_ff + WA_W'(n_next);
            end
         end
         ST_DRAIN: begin
            if (!status.busy) begin
               if (layer_ff == LAYER_OUT) begin
                  state_in = ST_PUBLISH;
               end else begin
                  state_in = ST_MAC;
                  layer_in = layer_ff + 2'd1;
                  i_in     = '0;
                  j_in     = '0;
                  wa_in    = '0;
               end
            end
         end
         ST_PUBLISH: begin
            if (!status.rsp_busy) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         layer_ff <= LAYER_H1;
         i_ff     <= '0;
         j_ff     <= '0;
         wa_ff    <= '0;
      end else begin
         state_ff <= state_in;
         layer_ff <= layer_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         wa_ff    <= wa_in;
      end
   end

   assign cmd.rd      = (state_ff == ST_MAC);
   assign cmd.first   = (i_ff == '0);
   assign cmd.last    = i_last;
   assign cmd.layer   = layer_ff;
   assign cmd.publish = (state_ff == ST_PUBLISH) && !status.rsp_busy;
   assign cmd_i       = i_ff;
   assign cmd_j       = j_ff;
   assign cmd_wa      = wa_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/mlp_three_layer_inference.sv
// Top level of the three-layer perceptron: register port, controller and datapath.
// Uses mlp_pkg, mlp_ctrl and mlp_datapath.
//
// Channel   Direction  Handshake              Payload
// req       in         req_tvalid/req_tready  req_tdata, req_tuser, req_tlast
// rsp       out        rsp_tvalid/rsp_tready  rsp_tdata
// csr       in         APB psel/penable       csr_paddr, csr_pwdata, csr_prdata
//
// Weight, bias and non-last activation transfers only write memories; req_tready stays high.
// A last activation runs every MAC of the three layers on the single multiplier, drains
// the pipeline after each layer and then publishes the result.
// req_tready is low for all of these; rsp_tvalid rises the cycle after publish.
// The publish state holds while an earlier result still waits in the output register.
// Reset is synchronous; memories hold no reset value and need no clearing.
`default_nettype none
module mlp_three_layer_inference
   import mlp_pkg::*;
#(
   parameter int MAX_INPUTS          = MAX_INPUTS_DEF,
   parameter int MAX_HIDDEN1         = MAX_HIDDEN1_DEF,
   parameter int MAX_HIDDEN2         = MAX_HIDDEN2_DEF,
   parameter int MAX_OUTPUTS         = MAX_OUTPUTS_DEF,
   parameter int SIGMOID_TABLE_DEPTH = SIG_DEPTH_DEF,
   localparam int W1_DEPTH = MAX_INPUTS * MAX_HIDDEN1,
   localparam int W2_DEPTH = MAX_HIDDEN1 * MAX_HIDDEN2,
   localparam int W3_DEPTH = MAX_HIDDEN2 * MAX_OUTPUTS,
   localparam int FANIN    = max2(max2(MAX_INPUTS, MAX_HIDDEN1), MAX_HIDDEN2),
   localparam int CNT_W    = $clog2(max2(FANIN, MAX_OUTPUTS) + 1),
   localparam int WA_W     = max2(clog2_min1(max2(max2(W1_DEPTH, W2_DEPTH), W3_DEPTH)), CNT_W)
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [55:0] req_tdata,   // index[16:0], coefficient[32:17], activation[48:33]
   input  wire logic [3:0]  req_tuser,   // mode[1:0], layer[3:2]
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // class_index[3:0], class_score[19:4]
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   cfg_type          cfg_ff;
   cmd_type          cmd;
   status_type       status;
   logic [CNT_W-1:0] cmd_i, cmd_j;
   logic [WA_W-1:0]  cmd_wa;
   logic             csr_wr, req_fire;
   logic [3:0]       class_index;
   logic [15:0]      class_score;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.input_count   <= INPUT_COUNT_RST;
         cfg_ff.hidden1_count <= HIDDEN1_COUNT_RST;
         cfg_ff.hidden2_count <= HIDDEN2_COUNT_RST;
         cfg_ff.output_count  <= OUTPUT_COUNT_RST;
      end else if (csr_wr) begin
         unique case (csr_paddr[3:2])
            REG_INPUT_COUNT:   cfg_ff.input_count   <= csr_pwdata[10:0];
            REG_HIDDEN1_COUNT: cfg_ff.hidden1_count <= csr_pwdata[7:0];
            REG_HIDDEN2_COUNT: cfg_ff.hidden2_count <= csr_pwdata[6:0];
            REG_OUTPUT_COUNT:  cfg_ff.output_count  <= csr_pwdata[4:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_INPUT_COUNT:   csr_prdata = 32'(cfg_ff.input_count);
         REG_HIDDEN1_COUNT: csr_prdata = 32'(cfg_ff.hidden1_count);
         REG_HIDDEN2_COUNT: csr_prdata = 32'(cfg_ff.hidden2_count);
         REG_OUTPUT_COUNT:  csr_prdata = 32'(cfg_ff.output_count);
         default:           csr_prdata = '0;
      endcase
   end

   assign req_fire = req_tvalid && req_tready;

   mlp_ctrl #(
      .MAX_INPUTS (MAX_INPUTS),
      .MAX_HIDDEN1(MAX_HIDDEN1),
      .MAX_HIDDEN2(MAX_HIDDEN2),
      .MAX_OUTPUTS(MAX_OUTPUTS)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_valid(req_tvalid),
      .req_ready(req_tready),
      .req_mode (req_tuser[1:0]),
      .req_last (req_tlast),
      .status   (status),
      .cmd      (cmd),
      .cmd_i    (cmd_i),
      .cmd_j    (cmd_j),
      .cmd_wa   (cmd_wa)
   );

   mlp_datapath #(
      .MAX_INPUTS (MAX_INPUTS),
      .MAX_HIDDEN1(MAX_HIDDEN1),
      .MAX_HIDDEN2(MAX_HIDDEN2),
      .MAX_OUTPUTS(MAX_OUTPUTS),
      .SIG_DEPTH  (SIGMOID_TABLE_DEPTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_fire       (req_fire),
      .req_mode       (req_tuser[1:0]),
      .req_layer      (req_tuser[3:2]),
      .req_index      (req_tdata[16:0]),
      .req_coef       (req_tdata[32:17]),
      .req_act        (req_tdata[48:33]),
      .cmd            (cmd),
      .cmd_i          (cmd_i),
      .cmd_j          (cmd_j),
      .cmd_wa         (cmd_wa),
      .status         (status),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp_class_index(class_index),
      .rsp_class_score(class_score)
   );

   assign rsp_tdata = {4'd0, class_score, class_index};

endmodule
`default_nettype wire

FILE: hw/rtl/mlp_checker.sv
// Port-level checker for the three-layer perceptron, bound to the top level.
// Uses mlp_pkg and the assertion macros of mlp_three_layer_inference_defines.svh.
`default_nettype none
`include "mlp_three_layer_inference_defines.svh"
module mlp_checker
   import mlp_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [3:0]  req_tuser,
   input wire logic        req_tlast,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata
);

   logic req_fire;
   assign req_fire = req_tvalid && req_tready;

   `MLP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `MLP_ASSERT_NEXT(a_busy_after_last, clock, reset, req_fire && (req_tuser[1:0] == MODE_ACT) && req_tlast, !req_tready)
   `MLP_ASSERT_IMP(a_rsp_after_run, clock, reset, $rose(rsp_tvalid), $past(!req_tready))
   `MLP_ASSERT_NEXT(a_no_rsp_on_write, clock, reset, req_fire && (req_tuser[1:0] != MODE_ACT), !$rose(rsp_tvalid))

endmodule

bind mlp_three_layer_inference mlp_checker u_checker (.*);
`default_nettype wire

FILE: test/mlp_three_layer_inference_checker.sv
`timescale 1ns / 1ps
// Checker of the three-layer perceptron: watches the register port and both streams,
// predicts each classification and compares it with the block's result. Uses mlp_pkg.
module mlp_three_layer_inference_checker
   import mlp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [55:0] req_tdata,   // index[16:0], coefficient[32:17], activation[48:33]
   input  wire logic [3:0]  req_tuser,   // mode[1:0], layer[3:2]
   input  wire logic        req_tlast,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [23:0] rsp_tdata,   // class_index[3:0], class_score[19:4]
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   input  wire logic        csr_pready,
   output int               error_count,
   output int               pending_count
);
   localparam int NI_MAX = MAX_INPUTS_DEF;
   localparam int NH1_MAX = MAX_HIDDEN1_DEF;
   localparam int NH2_MAX = MAX_HIDDEN2_DEF;
   localparam int NO_MAX = MAX_OUTPUTS_DEF;
   localparam int DEPTH = SIG_DEPTH_DEF;

   typedef struct packed {
      logic [3:0]  class_index;
      logic [15:0] class_score;
   } verdict_type;

   verdict_type verdict_q[$];
   cfg_type cfg;
   logic [15:0] sig_lut [DEPTH];
   logic [15:0] pixel_mem [NI_MAX];
   logic signed [15:0] w1_mem [NI_MAX * NH1_MAX];
   logic signed [15:0] w2_mem [NH1_MAX * NH2_MAX];
   logic signed [15:0] w3_mem [NH2_MAX * NO_MAX];
   logic signed [15:0] b1_mem [NH1_MAX];
   logic signed [15:0] b2_mem [NH2_MAX];
   logic signed [15:0] b3_mem [NO_MAX];
   logic [15:0] h1_act [NH1_MAX];
   logic [15:0] h2_act [NH2_MAX];
   logic [15:0] out_act [NO_MAX];

   function automatic logic [63:0] decay_q31(input logic [63:0] a);
      logic [63:0] y, y2, y3, y4, e;
      y = a << 11;
      y2 = (y * y) >> 31;
      y3 = (y2 * y) >> 31;
      y4 = (y3 * y) >> 31;
      e = (64'd1 << 31) + y2 / 2 + y4 / 24 - y - y3 / 6;
      for (int n = 0; n < 8; n++) e = (e * e) >> 31;
      return e;
   endfunction

   function automatic int bound_count(input int v, input int max_v);
      if (v < 1) return 1;
      return (v > max_v) ? max_v : v;
   endfunction

   function automatic logic [15:0] squash(input longint acc_in);
      longint acc;
      longint unsigned u;
      acc = acc_in;
      if (acc < -(64'sd1 <<< 31)) acc = -(64'sd1 <<< 31);
      if (acc > (64'sd1 <<< 31) - 1) acc = (64'sd1 <<< 31) - 1;
      u = longint'(acc + (64'sd1 <<< 31));
      return sig_lut[(u * DEPTH) >> 32];
   endfunction

   initial begin
      int xq;
      logic [63:0] a, e, den, s;
      for (int k = 0; k < DEPTH; k++) begin
         xq = -32768 + ((2 * k + 1) * 32768) / DEPTH;
         a = (xq < 0) ? 64'(-xq) : 64'(xq);
         e = decay_q31(a);
         den = (64'd1 << 31) + e;
         if (xq >= 0) s = ((64'd1 << 47) + den / 2) / den;
         else s = ((e << 16) + den / 2) / den;
         if (s > 64'd65535) s = 64'd65535;
         sig_lut[k] = s[15:0];
      end
      error_count = 0;
      pending_count = 0;
   end

   task automatic classify();
      int ni, nh1, nh2, no, best;
      longint acc;
      verdict_type v;
      ni = bound_count(int'(cfg.input_count), NI_MAX);
      nh1 = bound_count(int'(cfg.hidden1_count), NH1_MAX);
      nh2 = bound_count(int'(cfg.hidden2_count), NH2_MAX);
      no = bound_count(int'(cfg.output_count), NO_MAX);
      for (int j = 0; j < nh1; j++) begin
         acc = longint'(b1_mem[j]) * 65536;
         for (int i = 0; i < ni; i++)
            acc += longint'({1'b0, pixel_mem[i]}) * longint'(w1_mem[i * nh1 + j]);
         h1_act[j] = squash(acc);
      end
      for (int j = 0; j < nh2; j++) begin
         acc = longint'(b2_mem[j]) * 65536;
         for (int i = 0; i < nh1; i++)
            acc += longint'({1'b0, h1_act[i]}) * longint'(w2_mem[i * nh2 + j]);
         h2_act[j] = squash(acc);
      end
      for (int j = 0; j < no; j++) begin
         acc = longint'(b3_mem[j]) * 65536;
         for (int i = 0; i < nh2; i++)
            acc += longint'({1'b0, h2_act[i]}) * longint'(w3_mem[i * no + j]);
         out_act[j] = squash(acc);
      end
      best = 0;
      for (int k = 1; k < no; k++)
         if (out_act[k] > out_act[best]) best = k;
      v.class_index = 4'(best);
      v.class_score = out_act[best];
      verdict_q.push_back(v);
   endtask

   always @(posedge clock) begin
      logic [1:0] mode, layer;
      logic [16:0] idx;
      logic [15:0] coef, act;
      verdict_type v;
      if (reset) begin
         verdict_q.delete();
         cfg.input_count = INPUT_COUNT_RST;
         cfg.hidden1_count = HIDDEN1_COUNT_RST;
         cfg.hidden2_count = HIDDEN2_COUNT_RST;
         cfg.output_count = OUTPUT_COUNT_RST;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               REG_INPUT_COUNT: cfg.input_count = csr_pwdata[10:0];
               REG_HIDDEN1_COUNT: cfg.hidden1_count = csr_pwdata[7:0];
               REG_HIDDEN2_COUNT: cfg.hidden2_count = csr_pwdata[6:0];
               REG_OUTPUT_COUNT: cfg.output_count = csr_pwdata[4:0];
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (verdict_q.size() == 0) begin
               $error("unexpected result transfer: class_index %0d class_score %0d",
                  rsp_tdata[3:0], rsp_tdata[19:4]);
               error_count++;
            end else begin
               v = verdict_q.pop_front();
               if (rsp_tdata[3:0] !== v.class_index) begin
                  $error("class_index expected %0d actual %0d", v.class_index, rsp_tdata[3:0]);
                  error_count++;
               end
               if (rsp_tdata[19:4] !== v.class_score) begin
                  $error("class_score expected %0d actual %0d", v.class_score, rsp_tdata[19:4]);
                  error_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            mode = req_tuser[1:0];
            layer = req_tuser[3:2];
            idx = req_tdata[16:0];
            coef = req_tdata[32:17];
            act = req_tdata[48:33];
            if (mode == MODE_WEIGHT) begin
               if (layer == LAYER_H1 && idx < NI_MAX * NH1_MAX) w1_mem[idx] = coef;
               else if (layer == LAYER_H2 && idx < NH1_MAX * NH2_MAX) w2_mem[idx] = coef;
               else if (layer == LAYER_OUT && idx < NH2_MAX * NO_MAX) w3_mem[idx] = coef;
            end else if (mode == MODE_BIAS) begin
               if (layer == LAYER_H1 && idx < NH1_MAX) b1_mem[idx] = coef;
               else if (layer == LAYER_H2 && idx < NH2_MAX) b2_mem[idx] = coef;
               else if (layer == LAYER_OUT && idx < NO_MAX) b3_mem[idx] = coef;
            end else if (mode == MODE_ACT) begin
               if (idx < NI_MAX) pixel_mem[idx] = act;
               if (req_tlast) classify();
            end
         end
      end
      pending_count = verdict_q.size();
   end
endmodule

FILE: test/tb_mlp_three_layer_inference.sv
`timescale 1ns / 1ps
// Testbench top of the three-layer perceptron: loads networks, streams samples and
// gives the verdict. Uses mlp_pkg, the block and mlp_three_layer_inference_checker.
module tb_mlp_three_layer_inference;
   import mlp_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [55:0] req_tdata = '0;
   logic [3:0] req_tuser = '0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [3:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;
   int error_count, pending_count;
   int cycle_count = 0;
   int send_idle_pct = 15;
   int recv_idle_pct = 68;
   int random_items = 0;
   int ni, nh1, nh2, no;

   mlp_three_layer_inference u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   mlp_three_layer_inference_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_pready(csr_pready),
      .error_count(error_count), .pending_count(pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(negedge clock) rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   function automatic logic [15:0] pick_coef();
      int r;
      r = $urandom_range(9);
      if (r == 0) return 16'h8000;
      if (r == 1) return 16'h7fff;
      if (r < 6) return 16'($urandom_range(65535));
      return 16'($urandom_range(4095) - 2048);
   endfunction

   function automatic logic [15:0] pick_act();
      int r;
      r = $urandom_range(9);
      if (r == 0) return 16'h0000;
      if (r == 1) return 16'hffff;
      return 16'($urandom_range(65535));
   endfunction

   function automatic int bound(input int v, input int max_v);
      if (v < 1) return 1;
      return (v > max_v) ? max_v : v;
   endfunction

   task automatic push(input logic [1:0] mode, input logic [1:0] layer, input logic [16:0] idx,
                       input logic [15:0] coef, input logic [15:0] act, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {7'd0, act, coef, idx};
      req_tuser <= {layer, mode};
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic push_noise();
      push(2'($urandom_range(3)), 2'($urandom_range(3)), 17'($urandom_range(131071)),
         16'($urandom_range(65535)), 16'($urandom_range(65535)), 1'($urandom_range(1)));
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (30) @(negedge clock);
   endtask

   task automatic csr_write(input logic [1:0] reg_idx, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {reg_idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // Sets the sizes and loads every weight, bias and input that inference reads.
   task automatic load_network(input int raw_ni, input int raw_nh1, input int raw_nh2,
                               input int raw_no);
      drain();
      csr_write(REG_INPUT_COUNT, raw_ni);
      csr_write(REG_HIDDEN1_COUNT, raw_nh1);
      csr_write(REG_HIDDEN2_COUNT, raw_nh2);
      csr_write(REG_OUTPUT_COUNT, raw_no);
      ni = bound(raw_ni & 'h7ff, MAX_INPUTS_DEF);
      nh1 = bound(raw_nh1 & 'hff, MAX_HIDDEN1_DEF);
      nh2 = bound(raw_nh2 & 'h7f, MAX_HIDDEN2_DEF);
      no = bound(raw_no & 'h1f, MAX_OUTPUTS_DEF);
      for (int k = 0; k < ni * nh1; k++)
         push(MODE_WEIGHT, LAYER_H1, 17'(k), pick_coef(), pick_act(), 1'($urandom_range(1)));
      for (int k = 0; k < nh1 * nh2; k++)
         push(MODE_WEIGHT, LAYER_H2, 17'(k), pick_coef(), pick_act(), 1'b0);
      for (int k = 0; k < nh2 * no; k++)
         push(MODE_WEIGHT, LAYER_OUT, 17'(k), pick_coef(), pick_act(), 1'b0);
      for (int k = 0; k < nh1; k++)
         push(MODE_BIAS, LAYER_H1, 17'(k), pick_coef(), 16'd0, 1'b0);
      for (int k = 0; k < nh2; k++)
         push(MODE_BIAS, LAYER_H2, 17'(k), pick_coef(), 16'd0, 1'b0);
      for (int k = 0; k < no; k++)
         push(MODE_BIAS, LAYER_OUT, 17'(k), pick_coef(), 16'd0, 1'b0);
      for (int k = 0; k < ni; k++)
         push(MODE_ACT, LAYER_H1, 17'(k), 16'd0, pick_act(), 1'b0);
   endtask

   // One sample: a few updates and noise, then the closing activation.
   task automatic run_sample(input bit count_it);
      int n, r;
      n = $urandom_range(ni < 12 ? ni : 12);
      for (int k = 0; k < n; k++) begin
         r = $urandom_range(99);
         if (r < 10) push_noise();
         else if (r < 25)
            push(MODE_WEIGHT, 2'($urandom_range(2)), 17'($urandom_range(nh2 * no - 1)),
               pick_coef(), 16'd0, 1'($urandom_range(1)));
         else if (r < 32)
            push(MODE_BIAS, LAYER_OUT, 17'($urandom_range(no - 1)), pick_coef(), 16'd0, 1'b0);
         else
            push(MODE_ACT, 2'($urandom_range(3)), 17'($urandom_range(ni - 1)), 16'd0,
               pick_act(), 1'b0);
         if (count_it) random_items++;
      end
      push(MODE_ACT, 2'($urandom_range(3)),
         ($urandom_range(9) == 0) ? 17'($urandom_range(131071)) : 17'($urandom_range(ni - 1)),
         pick_coef(), pick_act(), 1'b1);
      if (count_it) random_items++;
   endtask

   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: all counts zero, used as one neuron per layer.
      load_network(0, 0, 0, 0);
      push(MODE_WEIGHT, LAYER_H1, 17'd0, 16'h7fff, 16'd0, 1'b1);
      push(MODE_WEIGHT, LAYER_H2, 17'd0, 16'h8000, 16'd0, 1'b0);
      push(MODE_WEIGHT, LAYER_OUT, 17'd0, 16'h7fff, 16'd0, 1'b0);
      push(MODE_BIAS, LAYER_H1, 17'd0, 16'h7fff, 16'd0, 1'b1);
      push(MODE_BIAS, LAYER_H2, 17'd0, 16'h8000, 16'd0, 1'b0);
      push(MODE_BIAS, LAYER_OUT, 17'd0, 16'h0000, 16'd0, 1'b0);
      push(MODE_ACT, LAYER_H1, 17'd0, 16'd0, 16'hffff, 1'b1);
      push(MODE_ACT, LAYER_H1, 17'd0, 16'd0, 16'h0000, 1'b1);
      push(MODE_WEIGHT, LAYER_H1, 17'd131071, 16'h8000, 16'd0, 1'b0);
      push(MODE_WEIGHT, LAYER_H2, 17'd131071, 16'h1234, 16'd0, 1'b0);
      push(MODE_BIAS, LAYER_H1, 17'd127, 16'h7fff, 16'd0, 1'b0);
      push(MODE_BIAS, LAYER_OUT, 17'd200, 16'h7fff, 16'd0, 1'b1);
      push(MODE_BIAS, 2'd3, 17'd0, 16'h8000, 16'd0, 1'b0);
      push(2'd3, LAYER_H1, 17'd0, 16'h8000, 16'hffff, 1'b1);
      push(MODE_ACT, 2'd3, 17'd131071, 16'd0, 16'hffff, 1'b1);
      push(MODE_ACT, LAYER_H1, 17'd1023, 16'd0, 16'hffff, 1'b0);
      push(MODE_ACT, LAYER_H1, 17'd0, 16'd0, 16'h8000, 1'b1);

      // Register extremes, with the layers that depend on them kept narrow.
      load_network(2047, 1, 1, 31);
      repeat (2) run_sample(1'b0);
      load_network(3, 255, 2, 5);
      repeat (2) run_sample(1'b0);
      load_network(2, 1, 127, 2);
      repeat (2) run_sample(1'b0);
      load_network(1024, 1, 64, 1);
      repeat (2) run_sample(1'b0);

      while (random_items < 650) begin
         if (random_items < 220) begin
            send_idle_pct = 15;
            recv_idle_pct = 68;
         end else if (random_items < 440) begin
            send_idle_pct = 68;
            recv_idle_pct = 15;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         load_network(($urandom_range(7) == 0) ? 0 : $urandom_range(1, 12),
            $urandom_range(1, 8), $urandom_range(1, 6),
            ($urandom_range(5) == 0) ? $urandom_range(16, 31) : $urandom_range(0, 16));
         repeat ($urandom_range(4, 10)) run_sample(1'b1);
      end

      drain();
      if (error_count == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/mlp_pkg.sv
hw/rtl/mlp_sigmoid_rom.sv
hw/rtl/mlp_datapath.sv
hw/rtl/mlp_ctrl.sv
hw/rtl/mlp_three_layer_inference.sv
hw/rtl/mlp_checker.sv
test/mlp_three_layer_inference_checker.sv
test/tb_mlp_three_layer_inference.sv
